[rtl/spimte_pkg.sv]
// shared types, codes and helpers for the spi master transaction engine
`default_nettype none

package spimte_pkg;

  // default buffer depth and number of select lines
  localparam int unsigned MaxBytesDefault = 16;
  localparam int unsigned NumSlaves       = 8;

  // request kinds carried in the input tuser
  localparam logic [1:0] ReqLoad  = 2'd0;
  localparam logic [1:0] ReqStart = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  // layout codes
  localparam logic [1:0] LayoutWrRd = 2'd1;
  localparam logic [1:0] LayoutRdWr = 2'd2;

  // register indexes on the apb port
  localparam logic [2:0] RegSpiMode    = 3'd0;
  localparam logic [2:0] RegLsbFirst   = 3'd1;
  localparam logic [2:0] RegLayoutMode = 3'd2;
  localparam logic [2:0] RegAlignRight = 3'd3;
  localparam logic [2:0] RegHalfPeriod = 3'd4;
  localparam logic [2:0] RegSetup      = 3'd5;
  localparam logic [2:0] RegByteGap    = 3'd6;
  localparam logic [2:0] RegTurnaround = 3'd7;

  // sequencer phases, one-hot
  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhSetup = 6'b000010,
    PhLead  = 6'b000100,
    PhTrail = 6'b001000,
    PhGap   = 6'b010000,
    PhTurn  = 6'b100000
  } phase_e;

  // bit reversal of one byte
  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/spi_master_transaction_engine.sv]
// spi master transaction engine: buffered write bytes, sequenced spi transfers
//
// Every input beat (load, start or tick) produces exactly one output beat with the pin
// levels after that beat, the received byte when one completes, and busy/done status.
// The sequencer state and a single output register are updated in the cycle a beat is
// accepted, so the block takes one beat per clock cycle; only the output register
// waiting on m_axis_tready holds it back. Spi time advances only on tick beats. Write
// bytes sit in a MAX_BYTES deep register buffer read at one address. The user writes
// configuration on the apb port only while no transfer runs; it is not enforced.
`default_nettype none

module spi_master_transaction_engine #(
  parameter int unsigned MAX_BYTES = spimte_pkg::MaxBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: write_byte[7:0], write_len[12:8], read_len[17:13], slave_index[20:18],
  //        use_select[21], miso[22], zero[23]
  input  wire logic [23:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: sclk[0], mosi[1], select_n[9:2], read_byte[17:10], read_index[21:18],
  //        busy_res[22], zero[23]
  output logic [23:0]      m_axis_tdata,
  // tuser: read_valid[0]
  output logic             m_axis_tuser,
  // tlast: done_res
  output logic             m_axis_tlast,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned LenW  = $clog2(MAX_BYTES + 1);
  localparam int unsigned SlotW = $clog2(2 * MAX_BYTES + 1);
  localparam int unsigned AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef struct packed {
    logic [SlotW-1:0] total;
    logic [SlotW-1:0] boundary;
    logic [SlotW-1:0] wi;
    logic [SlotW-1:0] ri;
    logic             turn;
    logic             wr;
    logic             rd;
  } plan_t;

  // configuration registers
  logic [1:0]  spi_mode_q;
  logic        lsb_first_q;
  logic [1:0]  layout_mode_q;
  logic        align_right_q;
  logic [15:0] half_q, setup_q, gap_q, turn_q;

  // sequencer state
  spimte_pkg::phase_e phase_q, phase_d;
  logic [15:0]      tick_q, tick_d;
  logic [2:0]       bit_q, bit_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [7:0]       tx_q, tx_d, rx_q, rx_d;
  logic [LenW-1:0]  wlen_q, wlen_d, rlen_q, rlen_d;
  logic [LenW-1:0]  load_ptr_q, load_ptr_d;
  logic [7:0]       sel_q, sel_d;
  logic             clk_q, clk_d, mosi_q, mosi_d;
  logic [7:0]       wbuf_q [MAX_BYTES];
  logic             buf_we;

  // output register
  logic        out_valid_q;
  logic [23:0] out_data_q, out_data_d;
  logic        out_user_q, out_last_q;

  // input fields
  logic [1:0] req_type;
  logic [7:0] write_byte;
  logic [4:0] write_len, read_len;
  logic [2:0] slave_index;
  logic       use_select, miso;
  logic       in_accept, cfg_we, cpol, cpha;

  assign req_type    = s_axis_tuser;
  assign write_byte  = s_axis_tdata[7:0];
  assign write_len   = s_axis_tdata[12:8];
  assign read_len    = s_axis_tdata[17:13];
  assign slave_index = s_axis_tdata[20:18];
  assign use_select  = s_axis_tdata[21];
  assign miso        = s_axis_tdata[22];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cpol          = spi_mode_q[1];
  assign cpha          = spi_mode_q[0];

  // slot plan: which direction and byte index a slot carries
  function automatic plan_t plan_slot(input logic [SlotW-1:0] s,
                                      input logic [LenW-1:0] wl,
                                      input logic [LenW-1:0] rl,
                                      input logic [1:0] layout,
                                      input logic align);
    plan_t p;
    logic [SlotW-1:0] w, r, lng, sht;
    logic wlong, sact;
    logic [SlotW-1:0] sidx;
    w = SlotW'(wl);
    r = SlotW'(rl);
    p = '0;
    wlong = w > r;
    lng = wlong ? w : r;
    sht = wlong ? r : w;
    sact = 1'b0;
    sidx = '0;
    if (layout == spimte_pkg::LayoutWrRd) begin
      p.total = w + r;
      p.boundary = w;
      if (s < w) begin
        p.wr = 1'b1;
        p.wi = s;
      end else begin
        p.rd = 1'b1;
        p.ri = s - w;
      end
    end else if (layout == spimte_pkg::LayoutRdWr) begin
      p.total = w + r;
      p.boundary = r;
      if (s < r) begin
        p.rd = 1'b1;
        p.ri = s;
      end else begin
        p.wr = 1'b1;
        p.wi = s - r;
      end
    end else if (w == r) begin
      p.total = w;
      p.boundary = w;
      p.wr = 1'b1;
      p.rd = 1'b1;
      p.wi = s;
      p.ri = s;
    end else begin
      p.total = lng;
      if (align) begin
        p.boundary = lng - sht;
        sact = s >= p.boundary;
        sidx = sact ? s - p.boundary : '0;
      end else begin
        p.boundary = sht;
        sact = s < sht;
        sidx = s;
      end
      if (wlong) begin
        p.wr = 1'b1;
        p.wi = s;
        p.rd = sact;
        p.ri = sidx;
      end else begin
        p.rd = 1'b1;
        p.ri = s;
        p.wr = sact;
        p.wi = sidx;
      end
    end
    p.turn = (w != '0) && (r != '0) && (p.boundary != '0) && (p.boundary < p.total);
    return p;
  endfunction

  // start beat fields after saturation and select check
  logic            is_start, sel_ok;
  logic [LenW-1:0] wlen_sat, rlen_sat;

  assign is_start = (req_type == spimte_pkg::ReqStart) && (phase_q == spimte_pkg::PhIdle);
  assign sel_ok   = use_select && (32'(slave_index) < spimte_pkg::NumSlaves);
  assign wlen_sat = (32'(write_len) > MAX_BYTES) ? LenW'(MAX_BYTES) : LenW'(write_len);
  assign rlen_sat = (32'(read_len) > MAX_BYTES) ? LenW'(MAX_BYTES) : LenW'(read_len);

  // slot that the next-slot or start-byte step looks at
  logic [SlotW-1:0] slot_eval;
  logic [LenW-1:0]  wlen_eval, rlen_eval;
  plan_t            plan_cur, plan_nxt;
  logic [7:0]       tx_fetch;

  always_comb begin
    slot_eval = slot_q;
    wlen_eval = wlen_q;
    rlen_eval = rlen_q;
    if (is_start) begin
      slot_eval = '0;
      wlen_eval = wlen_sat;
      rlen_eval = rlen_sat;
    end else if (phase_q == spimte_pkg::PhTrail) begin
      slot_eval = slot_q + 1'b1;
    end
  end

  assign plan_cur = plan_slot(slot_q, wlen_q, rlen_q, layout_mode_q, align_right_q);
  assign plan_nxt = plan_slot(slot_eval, wlen_eval, rlen_eval, layout_mode_q, align_right_q);

  // byte to send in the next slot
  always_comb begin
    tx_fetch = '0;
    if (plan_nxt.wr && (32'(plan_nxt.wi) < MAX_BYTES)) begin
      tx_fetch = wbuf_q[plan_nxt.wi[AddrW-1:0]];
    end
    if (lsb_first_q) begin
      tx_fetch = spimte_pkg::flip8(tx_fetch);
    end
  end

  // sequencer next state and result of the beat
  logic [15:0] half_eff;
  logic [16:0] tick_inc;
  logic        go_next, go_byte, done, rvalid;
  logic [7:0]  rbyte;
  logic [3:0]  ridx;

  assign half_eff = (half_q == '0) ? 16'd1 : half_q;
  assign tick_inc = {1'b0, tick_q} + 17'd1;

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    bit_d      = bit_q;
    slot_d     = slot_q;
    tx_d       = tx_q;
    rx_d       = rx_q;
    wlen_d     = wlen_q;
    rlen_d     = rlen_q;
    load_ptr_d = load_ptr_q;
    sel_d      = sel_q;
    clk_d      = clk_q;
    mosi_d     = mosi_q;
    buf_we     = 1'b0;
    go_next    = 1'b0;
    go_byte    = 1'b0;
    done       = 1'b0;
    rvalid     = 1'b0;
    rbyte      = '0;
    ridx       = '0;

    if (req_type == spimte_pkg::ReqLoad) begin
      if ((phase_q == spimte_pkg::PhIdle) && (32'(load_ptr_q) < MAX_BYTES)) begin
        buf_we     = 1'b1;
        load_ptr_d = load_ptr_q + 1'b1;
      end
    end else if (is_start) begin
      wlen_d     = wlen_sat;
      rlen_d     = rlen_sat;
      load_ptr_d = '0;
      slot_d     = '0;
      clk_d      = cpol;
      if (sel_ok) begin
        sel_d = ~(8'd1 << slave_index);
      end
      if (sel_ok && (setup_q != '0)) begin
        phase_d = spimte_pkg::PhSetup;
        tick_d  = '0;
      end else begin
        go_next = 1'b1;
      end
    end else if (req_type == spimte_pkg::ReqTick) begin
      tick_d = tick_inc[15:0];
      case (phase_q)
        spimte_pkg::PhSetup: begin
          if (tick_inc >= {1'b0, setup_q}) go_next = 1'b1;
        end
        spimte_pkg::PhLead: begin
          clk_d  = ~cpol;
          mosi_d = tx_q[7];
          if (!cpha && (tick_q == '0)) rx_d = {rx_q[6:0], miso};
          if (tick_inc >= {1'b0, half_eff}) begin
            phase_d = spimte_pkg::PhTrail;
            tick_d  = '0;
          end
        end
        spimte_pkg::PhTrail: begin
          clk_d = cpol;
          if (cpha && (tick_q == '0)) rx_d = {rx_q[6:0], miso};
          if (tick_inc >= {1'b0, half_eff}) begin
            tx_d  = {tx_q[6:0], 1'b0};
            bit_d = bit_q + 1'b1;
            if (bit_d != '0) begin
              phase_d = spimte_pkg::PhLead;
              tick_d  = '0;
              if (!cpha) mosi_d = tx_d[7];
            end else begin
              if (plan_cur.rd) begin
                rvalid = 1'b1;
                rbyte  = lsb_first_q ? spimte_pkg::flip8(rx_d) : rx_d;
                ridx   = 4'(plan_cur.ri);
              end
              slot_d = slot_eval;
              if (gap_q != '0) begin
                phase_d = spimte_pkg::PhGap;
                tick_d  = '0;
              end else begin
                go_next = 1'b1;
              end
            end
          end
        end
        spimte_pkg::PhGap: begin
          clk_d = cpol;
          if (tick_inc >= {1'b0, gap_q}) go_next = 1'b1;
        end
        spimte_pkg::PhTurn: begin
          if (tick_inc >= {1'b0, turn_q}) go_byte = 1'b1;
        end
        default: begin
          tick_d = tick_q;
        end
      endcase
    end

    // move on to the next slot, a turnaround or the end of the transfer
    if (go_next) begin
      if (slot_eval >= plan_nxt.total) begin
        sel_d   = 8'hFF;
        phase_d = spimte_pkg::PhIdle;
        clk_d   = cpol;
        tick_d  = '0;
        done    = 1'b1;
      end else if (plan_nxt.turn && (slot_eval == plan_nxt.boundary) && (turn_q != '0)) begin
        phase_d = spimte_pkg::PhTurn;
        tick_d  = '0;
      end else begin
        go_byte = 1'b1;
      end
    end

    // load the shifter and enter the first bit
    if (go_byte) begin
      tx_d    = tx_fetch;
      rx_d    = '0;
      bit_d   = '0;
      phase_d = spimte_pkg::PhLead;
      tick_d  = '0;
      if (!cpha) mosi_d = tx_fetch[7];
    end

    out_data_d = {1'b0, (phase_d != spimte_pkg::PhIdle), ridx, rbyte, sel_d, mosi_d, clk_d};
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= spimte_pkg::PhIdle;
      tick_q     <= '0;
      bit_q      <= '0;
      slot_q     <= '0;
      tx_q       <= '0;
      rx_q       <= '0;
      wlen_q     <= '0;
      rlen_q     <= '0;
      load_ptr_q <= '0;
      sel_q      <= 8'hFF;
      clk_q      <= 1'b0;
      mosi_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q    <= phase_d;
        tick_q     <= tick_d;
        bit_q      <= bit_d;
        slot_q     <= slot_d;
        tx_q       <= tx_d;
        rx_q       <= rx_d;
        wlen_q     <= wlen_d;
        rlen_q     <= rlen_d;
        load_ptr_q <= load_ptr_d;
        sel_q      <= sel_d;
        clk_q      <= clk_d;
        mosi_q     <= mosi_d;
      end else if (cfg_we && (paddr[4:2] == spimte_pkg::RegSpiMode) &&
                   (phase_q == spimte_pkg::PhIdle)) begin
        // idle clock level follows a new polarity
        clk_q <= pwdata[1];
      end
    end
  end

  // write buffer, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept && buf_we) begin
      wbuf_q[load_ptr_q[AddrW-1:0]] <= write_byte;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
      out_user_q <= rvalid;
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // apb register writes
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spi_mode_q    <= '0;
      lsb_first_q   <= 1'b0;
      layout_mode_q <= '0;
      align_right_q <= 1'b0;
      half_q        <= 16'd1;
      setup_q       <= '0;
      gap_q         <= '0;
      turn_q        <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        spimte_pkg::RegSpiMode:    spi_mode_q    <= pwdata[1:0];
        spimte_pkg::RegLsbFirst:   lsb_first_q   <= pwdata[0];
        spimte_pkg::RegLayoutMode: layout_mode_q <= pwdata[1:0];
        spimte_pkg::RegAlignRight: align_right_q <= pwdata[0];
        spimte_pkg::RegHalfPeriod: half_q        <= pwdata[15:0];
        spimte_pkg::RegSetup:      setup_q       <= pwdata[15:0];
        spimte_pkg::RegByteGap:    gap_q         <= pwdata[15:0];
        spimte_pkg::RegTurnaround: turn_q        <= pwdata[15:0];
        default: begin
          spi_mode_q <= spi_mode_q;
        end
      endcase
    end
  end

  // apb register reads
  always_comb begin
    case (paddr[4:2])
      spimte_pkg::RegSpiMode:    prdata = 32'(spi_mode_q);
      spimte_pkg::RegLsbFirst:   prdata = 32'(lsb_first_q);
      spimte_pkg::RegLayoutMode: prdata = 32'(layout_mode_q);
      spimte_pkg::RegAlignRight: prdata = 32'(align_right_q);
      spimte_pkg::RegHalfPeriod: prdata = 32'(half_q);
      spimte_pkg::RegSetup:      prdata = 32'(setup_q);
      spimte_pkg::RegByteGap:    prdata = 32'(gap_q);
      spimte_pkg::RegTurnaround: prdata = 32'(turn_q);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire
